@@ rtl/core/msl_pkg.sv @@
// Shared types, constants and helper functions for the speed limiter core.
`default_nettype none
package msl_pkg;

  localparam int NUM_CHANNELS_DEF = 4;
  localparam int MAX_CHANNELS     = 4;

  localparam int SPEED_W    = 16;
  localparam int WIDE_W     = 17;
  localparam int COUNT_W    = 3;
  localparam int FALLBACK_W = 15;
  localparam int TIMEOUT_W  = 16;
  localparam int AGE_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int DIVIDEND_W = 32;
  localparam int DIVISOR_W  = 17;
  localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);

  localparam logic [FALLBACK_W-1:0] FALLBACK_RST = 15'd2048;
  localparam logic [AGE_W-1:0]      AGE_MAX      = 16'hFFFF;

  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FALLBACK      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT0      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT1      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT2      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT3      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_MASK     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_CONF_MASK     = 3'd7;

  typedef enum logic [1:0] {
    OP_VEL    = 2'd0,
    OP_LIMIT  = 2'd1,
    OP_ENABLE = 2'd2,
    OP_TICK   = 2'd3
  } op_t;

  typedef struct packed {
    logic accept;
    logic clamp_step;
    logic mul;
    logic load_out;
  } msl_cmd_t;

  typedef struct packed {
    logic clamp_last;
    logic skip_div;
    logic div_done;
    logic out_free;
  } msl_sts_t;

  // Clamp to at most lim, then to at least -lim.
  function automatic logic signed [WIDE_W-1:0] clamp17(
    input logic signed [WIDE_W-1:0] l,
    input logic signed [WIDE_W-1:0] lim
  );
    logic signed [WIDE_W-1:0] t;
    logic signed [WIDE_W-1:0] neg;
    t   = (lim < l) ? lim : l;
    neg = -lim;
    t   = (t < neg) ? neg : t;
    return t;
  endfunction

  function automatic logic signed [SPEED_W-1:0] sat16(
    input logic signed [WIDE_W-1:0] v
  );
    logic signed [SPEED_W-1:0] r;
    if (v > 17'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -17'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[SPEED_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/msl_div.sv @@
// Bit-serial restoring divider for unsigned magnitudes, one quotient bit per cycle.
`default_nettype none
module msl_div (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  input  wire logic [msl_pkg::DIVIDEND_W-1:0]    dividend,
  input  wire logic [msl_pkg::DIVISOR_W-1:0]     divisor,
  output logic                                   done,
  output logic [msl_pkg::DIVIDEND_W-1:0]         quotient
);

  localparam int DW = msl_pkg::DIVIDEND_W;
  localparam int VW = msl_pkg::DIVISOR_W;
  localparam int CW = msl_pkg::DIV_CNT_W;

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [VW-1:0] div_r;
  logic [VW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] q_r, q_nxt;
  logic [VW-1:0] shifted;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    shifted  = {rem_r[VW-2:0], q_r[DW-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(DW - 1);
      rem_nxt  = '0;
      q_nxt    = dividend;
    end else if (busy_r) begin
      if (shifted >= div_r) begin
        rem_nxt = shifted - div_r;
        q_nxt   = {q_r[DW-2:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        q_nxt   = {q_r[DW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    if (start) begin
      div_r <= divisor;
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule
`default_nettype wire

@@ rtl/core/msl_dp.sv @@
// Datapath: configuration registers, channel state, clamp, rescale and output register.
`default_nettype none
module msl_dp #(
  parameter int NUM_CHANNELS = msl_pkg::NUM_CHANNELS_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire msl_pkg::msl_cmd_t                      cmd,
  output msl_pkg::msl_sts_t                           sts,
  input  wire logic                                   cfg_we,
  input  wire logic [msl_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  wire logic [msl_pkg::CFG_DATA_W-1:0]         cfg_wdata,
  input  wire logic [1:0]                             in_operation,
  input  wire logic [1:0]                             in_channel,
  input  wire logic signed [msl_pkg::SPEED_W-1:0]     in_linear_in,
  input  wire logic signed [msl_pkg::SPEED_W-1:0]     in_angular_in,
  input  wire logic signed [msl_pkg::SPEED_W-1:0]     in_limit_value,
  input  wire logic                                   in_enable_value,
  input  wire logic                                   out_stall,
  output logic                                        out_valid,
  output logic signed [msl_pkg::SPEED_W-1:0]          out_linear_out,
  output logic signed [msl_pkg::SPEED_W-1:0]          out_angular_out
);

  localparam int SW    = msl_pkg::SPEED_W;
  localparam int WW    = msl_pkg::WIDE_W;
  localparam int AW    = msl_pkg::AGE_W;
  localparam int TW    = msl_pkg::TIMEOUT_W;
  localparam int NW    = msl_pkg::COUNT_W;
  localparam int MC    = msl_pkg::MAX_CHANNELS;
  localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  // Configuration registers
  logic [NW-1:0]                    chan_count_r;
  logic [msl_pkg::FALLBACK_W-1:0]   fallback_r;
  logic [TW-1:0]                    timeout_r [MC];
  logic [MC-1:0]                    stop_mask_r;
  logic [MC-1:0]                    conf_mask_r;

  // Channel state
  logic signed [SW-1:0]             limit_r [NUM_CHANNELS];
  logic [AW-1:0]                    age_r   [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0]          enabled_r;

  // Working registers
  logic [IDX_W-1:0]                 idx_r;
  logic signed [SW-1:0]             lin_r;
  logic signed [WW-1:0]             l_r;
  logic signed [SW-1:0]             r_r;
  logic signed [SW-1:0]             lsat_r;
  logic signed [SW-1:0]             ang_res_r;
  logic                             q_neg_r;
  logic                             out_valid_r, out_valid_nxt;
  logic signed [SW-1:0]             out_lin_r;
  logic signed [SW-1:0]             out_ang_r;

  logic [NW-1:0]                    n_eff;
  logic signed [SW-1:0]             lim_sel;
  logic [AW-1:0]                    age_sel;
  logic [TW-1:0]                    to_sel;
  logic                             en_sel;
  logic                             stop_sel;
  logic                             active;
  logic                             expired;
  logic signed [WW-1:0]             lim_eff;
  logic signed [WW-1:0]             l_step;
  logic                             zero_ang;
  logic signed [SW-1:0]             l_sat;
  logic signed [2*SW-1:0]           prod;
  logic [msl_pkg::DIVIDEND_W-1:0]   prod_mag;
  logic signed [WW-1:0]             lin_ext;
  logic [msl_pkg::DIVISOR_W-1:0]    lin_mag;
  logic                             skip;
  logic                             div_start;
  logic                             div_done;
  logic [msl_pkg::DIVIDEND_W-1:0]   quot;
  logic [msl_pkg::DIVIDEND_W-1:0]   quot_neg;
  logic signed [SW-1:0]             ang_div;
  logic                             is_limit;
  logic                             is_enable;
  logic                             is_tick;
  logic                             ch_active;

  assign n_eff = (chan_count_r > NW'(NUM_CHANNELS)) ? NW'(NUM_CHANNELS) : chan_count_r;

  assign is_limit  = cmd.accept && (msl_pkg::op_t'(in_operation) == msl_pkg::OP_LIMIT);
  assign is_enable = cmd.accept && (msl_pkg::op_t'(in_operation) == msl_pkg::OP_ENABLE);
  assign is_tick   = cmd.accept && (msl_pkg::op_t'(in_operation) == msl_pkg::OP_TICK);
  assign ch_active = {1'b0, in_channel} < n_eff;

  // Per-step channel selection for the clamp sequence.
  always_comb begin
    lim_sel  = '0;
    age_sel  = '0;
    to_sel   = '0;
    en_sel   = 1'b0;
    stop_sel = 1'b0;
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      if (idx_r == IDX_W'(c)) begin
        lim_sel  = limit_r[c];
        age_sel  = age_r[c];
        to_sel   = timeout_r[c];
        en_sel   = enabled_r[c];
        stop_sel = stop_mask_r[c];
      end
    end
  end

  always_comb begin
    active   = NW'(idx_r) < n_eff;
    expired  = active && (to_sel != '0) && (age_sel > to_sel);
    lim_eff  = expired ? '0 : WW'(lim_sel);
    l_step   = l_r;
    zero_ang = 1'b0;
    if (n_eff == '0) begin
      if (idx_r == '0) begin
        l_step = msl_pkg::clamp17(l_r, $signed({2'b00, fallback_r}));
      end
    end else if (active && en_sel) begin
      l_step   = msl_pkg::clamp17(l_r, lim_eff);
      zero_ang = (lim_eff == '0) && stop_sel;
    end
  end

  // Saturate, multiply and set up the rescale division.
  always_comb begin
    l_sat    = msl_pkg::sat16(l_r);
    prod     = r_r * l_sat;
    prod_mag = prod[2*SW-1] ? msl_pkg::DIVIDEND_W'(-prod) : msl_pkg::DIVIDEND_W'(prod);
    lin_ext  = WW'(lin_r);
    lin_mag  = lin_ext[WW-1] ? msl_pkg::DIVISOR_W'(-lin_ext) : msl_pkg::DIVISOR_W'(lin_ext);
    skip     = (lin_r == '0) || (l_sat == '0);
    div_start = cmd.mul && !skip;
  end

  msl_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod_mag),
    .divisor  (lin_mag),
    .done     (div_done),
    .quotient (quot)
  );

  always_comb begin
    quot_neg = '0 - quot;
    if (!q_neg_r) begin
      ang_div = (quot > 32'd32767) ? 16'sh7FFF : quot[SW-1:0];
    end else begin
      ang_div = (quot > 32'd32768) ? 16'sh8000 : quot_neg[SW-1:0];
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_count_r <= '0;
      fallback_r   <= msl_pkg::FALLBACK_RST;
      stop_mask_r  <= '0;
      conf_mask_r  <= '0;
      for (int c = 0; c < MC; c++) begin
        timeout_r[c] <= '0;
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        msl_pkg::CFG_CHANNEL_COUNT: chan_count_r <= cfg_wdata[NW-1:0];
        msl_pkg::CFG_FALLBACK:      fallback_r   <= cfg_wdata[msl_pkg::FALLBACK_W-1:0];
        msl_pkg::CFG_TIMEOUT0:      timeout_r[0] <= cfg_wdata[TW-1:0];
        msl_pkg::CFG_TIMEOUT1:      timeout_r[1] <= cfg_wdata[TW-1:0];
        msl_pkg::CFG_TIMEOUT2:      timeout_r[2] <= cfg_wdata[TW-1:0];
        msl_pkg::CFG_TIMEOUT3:      timeout_r[3] <= cfg_wdata[TW-1:0];
        msl_pkg::CFG_STOP_MASK:     stop_mask_r  <= cfg_wdata[MC-1:0];
        msl_pkg::CFG_CONF_MASK:     conf_mask_r  <= cfg_wdata[MC-1:0];
        default: ;
      endcase
    end
  end

  // Channel state: updates on transfer, expiry during the clamp sequence.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r <= '1;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        limit_r[c] <= '0;
        age_r[c]   <= '0;
      end
    end else begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        if (is_limit && ch_active && (in_channel == 2'(c))) begin
          limit_r[c] <= in_limit_value;
          age_r[c]   <= '0;
        end
        if (is_enable && ch_active && (in_channel == 2'(c)) && conf_mask_r[c]) begin
          enabled_r[c] <= in_enable_value;
        end
        if (is_tick && (age_r[c] != msl_pkg::AGE_MAX)) begin
          age_r[c] <= age_r[c] + AW'(1);
        end
        if (cmd.clamp_step && expired && (idx_r == IDX_W'(c))) begin
          limit_r[c] <= '0;
        end
      end
    end
  end

  // Working registers of one velocity command
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      idx_r <= '0;
      lin_r <= in_linear_in;
      l_r   <= WW'(in_linear_in);
      r_r   <= in_angular_in;
    end else if (cmd.clamp_step) begin
      idx_r <= idx_r + IDX_W'(1);
      l_r   <= l_step;
      if (zero_ang) begin
        r_r <= '0;
      end
    end
    if (cmd.mul) begin
      lsat_r  <= l_sat;
      q_neg_r <= prod[2*SW-1] ^ lin_r[SW-1];
      if (skip) begin
        ang_res_r <= r_r;
      end
    end else if (div_done) begin
      ang_res_r <= ang_div;
    end
    if (cmd.load_out) begin
      out_lin_r <= lsat_r;
      out_ang_r <= ang_res_r;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign sts.clamp_last = (idx_r == IDX_W'(NUM_CHANNELS - 1));
  assign sts.skip_div   = skip;
  assign sts.div_done   = div_done;
  assign sts.out_free   = !out_valid_r || !out_stall;

  assign out_valid       = out_valid_r;
  assign out_linear_out  = out_lin_r;
  assign out_angular_out = out_ang_r;

endmodule
`default_nettype wire

@@ rtl/core/msl_ctrl.sv @@
// Controller state machine that sequences the clamp, multiply, divide and output steps.
`default_nettype none
module msl_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic [1:0]         in_operation,
  output logic                    in_stall,
  output msl_pkg::msl_cmd_t       cmd,
  input  wire msl_pkg::msl_sts_t  sts
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_CLAMP = 5'b00010,
    ST_MUL   = 5'b00100,
    ST_DIV   = 5'b01000,
    ST_OUT   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    in_stall       = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
        if (in_valid && (msl_pkg::op_t'(in_operation) == msl_pkg::OP_VEL)) begin
          state_nxt = ST_CLAMP;
        end
      end
      ST_CLAMP: begin
        cmd.clamp_step = 1'b1;
        if (sts.clamp_last) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = sts.skip_div ? ST_OUT : ST_DIV;
      end
      ST_DIV: begin
        if (sts.div_done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/multi_source_speed_limiter_core.sv @@
// Top level of the multi-source speed limiter: controller plus datapath.
`default_nettype none
//
//  Channel | Handshake            | Payload
//  --------+----------------------+------------------------------------------------
//  in      | in_valid / in_stall  | operation, channel, linear_in, angular_in,
//          |                      | limit_value, enable_value
//  out     | out_valid / out_stall| linear_out, angular_out (velocity commands only)
//  cfg     | cfg_we               | cfg_index, cfg_wdata (no read-back)
//
//  Limit, enable and tick transfers keep the controller idle: the input is ready
//  again on the next cycle. A velocity command runs one clamp step per channel,
//  the multiply, the 32-step bit-serial division when a rescale is needed, and
//  the output load, in that order.
//  A finished result sits in the output register while the next item is taken;
//  a second velocity result waits in the datapath until that register frees.
//  Reset is synchronous and active low; it restores the register defaults,
//  clears channel limits and ages and enables every channel.
//
module multi_source_speed_limiter_core #(
  parameter int NUM_CHANNELS = msl_pkg::NUM_CHANNELS_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  // Configuration port
  input  wire logic                                   cfg_we,
  input  wire logic [msl_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  wire logic [msl_pkg::CFG_DATA_W-1:0]         cfg_wdata,
  // Input channel
  input  wire logic                                   in_valid,
  output logic                                        in_stall,
  input  wire logic [1:0]                             in_operation,
  input  wire logic [1:0]                             in_channel,
  input  wire logic signed [msl_pkg::SPEED_W-1:0]     in_linear_in,
  input  wire logic signed [msl_pkg::SPEED_W-1:0]     in_angular_in,
  input  wire logic signed [msl_pkg::SPEED_W-1:0]     in_limit_value,
  input  wire logic                                   in_enable_value,
  // Result channel
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output logic signed [msl_pkg::SPEED_W-1:0]          out_linear_out,
  output logic signed [msl_pkg::SPEED_W-1:0]          out_angular_out
);

  // The controller only sees the operation code of an incoming transfer;
  // everything else moves through the datapath under command of the controller.
  msl_pkg::msl_cmd_t cmd;
  msl_pkg::msl_sts_t sts;

  msl_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .in_stall     (in_stall),
    .cmd          (cmd),
    .sts          (sts)
  );

  // The datapath holds the configuration registers, the per-channel limit,
  // age and enable state, the clamp step, the rescale multiplier and divider,
  // and the output register that decouples the result side.
  msl_dp #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_operation    (in_operation),
    .in_channel      (in_channel),
    .in_linear_in    (in_linear_in),
    .in_angular_in   (in_angular_in),
    .in_limit_value  (in_limit_value),
    .in_enable_value (in_enable_value),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_linear_out  (out_linear_out),
    .out_angular_out (out_angular_out)
  );

endmodule
`default_nettype wire
